FILE: hw/rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types and constants of the echo range median filter.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int SAMPLE_W = 15;
  localparam int TIME_W   = 32;
  localparam int DIST_W   = 10;

  // cm = floor(t * 1716 / 100000) = (t * SCALE_MUL) >> SCALE_SHIFT for t < 2^15
  localparam int SCALE_SHIFT = 32;
  localparam int SCALE_MUL_W = 27;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 27'd73701639;

  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 15'd26233;

  typedef enum logic [1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_RISE    = 2'd1,
    KIND_FALL    = 2'd2,
    KIND_READ    = 2'd3
  } erm_kind_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_LATEST = 2'd1,
    SRC_MEDIAN = 2'd2
  } erm_src_t;

  // control broadcast to every sort cell
  typedef struct packed {
    logic load;
    logic step;
    logic odd;
  } erm_sort_ctl_t;

endpackage

FILE: hw/rtl/erm_sort_cell.sv
// ----------------------------------------------------------------------------
// erm_sort_cell
// One cell of the odd-even transposition sorter: holds one sample and
// compare-exchanges with the neighbor it pairs with in the current phase.
// ----------------------------------------------------------------------------
module erm_sort_cell #(
  parameter int IDX    = 0,
  parameter int WINDOW = 7
) (
  input  logic                          clk,
  input  erm_pkg::erm_sort_ctl_t        ctl,
  input  logic [erm_pkg::SAMPLE_W-1:0]  load_val,
  input  logic [erm_pkg::SAMPLE_W-1:0]  left_val,
  input  logic [erm_pkg::SAMPLE_W-1:0]  right_val,
  output logic [erm_pkg::SAMPLE_W-1:0]  val
);
  import erm_pkg::*;

  localparam bit HAS_RIGHT = (IDX + 1) < WINDOW;
  localparam bit HAS_LEFT  = IDX > 0;
  localparam bit IS_ODD    = (IDX % 2) == 1;

  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;
  logic                is_left;
  logic                is_right;

  always_comb begin
    if (ctl.odd) begin
      is_left  = IS_ODD && HAS_RIGHT;
      is_right = !IS_ODD && HAS_LEFT;
    end else begin
      is_left  = !IS_ODD && HAS_RIGHT;
      is_right = IS_ODD;
    end

    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = load_val;
    end else if (ctl.step && is_left) begin
      val_nxt = (right_val < val_r) ? right_val : val_r;
    end else if (ctl.step && is_right) begin
      val_nxt = (left_val > val_r) ? left_val : val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: hw/rtl/erm_scale.sv
// ----------------------------------------------------------------------------
// erm_scale
// Echo time to centimeters by reciprocal multiply, product registered.
// ----------------------------------------------------------------------------
module erm_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [erm_pkg::SAMPLE_W-1:0]  time_val,
  output logic [erm_pkg::DIST_W-1:0]    dist_cm
);
  import erm_pkg::*;

  localparam int PROD_W = SAMPLE_W + SCALE_MUL_W;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(time_val) * PROD_W'(SCALE_MUL);
    end
  end

  assign dist_cm = prod_r[SCALE_SHIFT +: DIST_W];

endmodule

FILE: hw/rtl/echo_range_median_filter_top.sv
// ----------------------------------------------------------------------------
// echo_range_median_filter_top
// Ultrasonic echo timing with a median-of-window distance filter.
// ----------------------------------------------------------------------------
// Trigger, rising-edge and falling-edge events are handled in the idle state.
// Once the window is full, a read loads the row of sort cells, runs WINDOW
// odd-even transposition phases in the cell chain, then the registered
// multiply, and then emits. Before the window is full a read skips the
// sort. The result sits in an output register, so trigger and edge events
// are taken while it waits; a further read waits until its slot is free.
// echo_limit_us is written on cfg_data.
module echo_range_median_filter_top #(
  parameter int WINDOW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [erm_pkg::TIME_W-1:0]    in_time_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [erm_pkg::DIST_W-1:0]    out_distance_cm,
  output logic [1:0]                    out_source,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [erm_pkg::SAMPLE_W-1:0]  cfg_data
);
  import erm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [SAMPLE_W-1:0] limit_r;
  logic                armed_r;
  logic [TIME_W-1:0]   echo_start_r;
  logic [SAMPLE_W-1:0] win_r [WINDOW];
  logic [CNT_W-1:0]    fill_cnt_r;
  logic                full_r;
  logic [CNT_W-1:0]    phase_r;
  erm_src_t            src_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_dist_r;
  erm_src_t            out_src_r;

  logic                in_xfer;
  erm_kind_t           kind;
  logic [TIME_W-1:0]   elapsed;
  logic [SAMPLE_W-1:0] sample;
  erm_sort_ctl_t       sort_ctl;
  logic [SAMPLE_W-1:0] cell_val [WINDOW];
  logic [SAMPLE_W-1:0] scale_in;
  logic [DIST_W-1:0]   scale_cm;
  logic                out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign kind      = erm_kind_t'(in_kind);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    elapsed = in_time_us - echo_start_r;
    if (elapsed > TIME_W'(limit_r)) begin
      sample = limit_r;
    end else begin
      sample = elapsed[SAMPLE_W-1:0];
    end
  end

  assign sort_ctl.load = in_xfer && (kind == KIND_READ) && full_r;
  assign sort_ctl.step = (state_r == ST_SORT);
  assign sort_ctl.odd  = phase_r[0];

  // row of sort cells, each pairs with a neighbor per phase
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_W-1:0] left_v;
    logic [SAMPLE_W-1:0] right_v;
    if (i == 0) begin : g_l0
      assign left_v = cell_val[i];
    end else begin : g_l
      assign left_v = cell_val[i-1];
    end
    if (i == WINDOW - 1) begin : g_rn
      assign right_v = cell_val[i];
    end else begin : g_r
      assign right_v = cell_val[i+1];
    end
    erm_sort_cell #(
      .IDX    (i),
      .WINDOW (WINDOW)
    ) u_cell (
      .clk       (clk),
      .ctl       (sort_ctl),
      .load_val  (win_r[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i])
    );
  end

  always_comb begin
    case (src_r)
      SRC_MEDIAN: scale_in = cell_val[WINDOW/2];
      SRC_LATEST: scale_in = win_r[0];
      default:    scale_in = '0;
    endcase
  end

  erm_scale u_scale (
    .clk      (clk),
    .en       (state_r == ST_MUL),
    .time_val (scale_in),
    .dist_cm  (scale_cm)
  );

  // newest sample at position 0; median does not care about order
  always_ff @(posedge clk) begin
    if (in_xfer && (kind == KIND_FALL) && armed_r) begin
      win_r[0] <= sample;
      for (int i = 1; i < WINDOW; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      limit_r      <= LIMIT_RESET;
      armed_r      <= 1'b0;
      echo_start_r <= '0;
      fill_cnt_r   <= '0;
      full_r       <= 1'b0;
      phase_r      <= '0;
      src_r        <= SRC_NONE;
      out_valid_r  <= 1'b0;
      out_dist_r   <= '0;
      out_src_r    <= SRC_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      // emit state sets the flag itself when it loads a new result
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            case (kind)
              KIND_TRIGGER: armed_r <= 1'b1;
              KIND_RISE: begin
                if (armed_r) begin
                  echo_start_r <= in_time_us;
                end
              end
              KIND_FALL: begin
                if (armed_r) begin
                  armed_r <= 1'b0;
                  if (fill_cnt_r == CNT_W'(WINDOW - 1)) begin
                    fill_cnt_r <= '0;
                    full_r     <= 1'b1;
                  end else begin
                    fill_cnt_r <= fill_cnt_r + CNT_W'(1);
                  end
                end
              end
              default: begin
                phase_r <= '0;
                if (full_r) begin
                  src_r   <= SRC_MEDIAN;
                  state_r <= ST_SORT;
                end else begin
                  src_r   <= (fill_cnt_r != '0) ? SRC_LATEST : SRC_NONE;
                  state_r <= ST_MUL;
                end
              end
            endcase
          end
        end
        ST_SORT: begin
          if (phase_r == CNT_W'(WINDOW - 1)) begin
            state_r <= ST_MUL;
          end else begin
            phase_r <= phase_r + CNT_W'(1);
          end
        end
        ST_MUL: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= scale_cm;
            out_src_r   <= src_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_cm = out_dist_r;
  assign out_source      = out_src_r;

endmodule

FILE: tb/sv/echo_range_median_filter_top_tb.sv
// ----------------------------------------------------------------------------
// echo_range_median_filter_top_tb
// Self-checking bench for the echo range median filter. A directed table
// covers reset, ignored edges, wraparound and clamping; random echo
// sequences then run under several echo limits. Each read result is
// matched to its table row or a cycle-free predictor of the window median.
// ----------------------------------------------------------------------------
module echo_range_median_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erm_pkg::*;

  localparam int WIN          = 7;
  localparam int DRAIN_CYCLES = 2 * (WIN + 3);

  typedef struct packed {
    logic [DIST_W-1:0] cm;
    erm_src_t          src;
  } reading_t;

  typedef struct {
    erm_kind_t         kind;
    logic [TIME_W-1:0] stamp;
    bit                fixed;
    logic [DIST_W-1:0] cm;
    erm_src_t          src;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_kind;
  logic [TIME_W-1:0]   in_time_us;
  logic                out_valid;
  logic                out_stall;
  logic [DIST_W-1:0]   out_distance_cm;
  logic [1:0]          out_source;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SAMPLE_W-1:0] cfg_data;

  // predicted state of the echo front end and sample ring
  bit                  armed_q    = 1'b0;
  logic [TIME_W-1:0]   start_q    = '0;
  logic [SAMPLE_W-1:0] ring_q [WIN];
  int                  wr_idx_q   = 0;
  bit                  full_q     = 1'b0;
  logic [SAMPLE_W-1:0] limit_q    = LIMIT_RESET;

  reading_t pending_readings[$];
  int       mismatches     = 0;
  int       effective_sent = 0;
  bit       calm_sender    = 1'b0;

  plan_row_t plan [22] = '{
    '{KIND_READ,    32'd0,          1'b1, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'd10,         1'b0, 10'd0,   SRC_NONE},
    '{KIND_FALL,    32'd20,         1'b0, 10'd0,   SRC_NONE},
    '{KIND_READ,    32'd0,          1'b1, 10'd0,   SRC_NONE},
    '{KIND_TRIGGER, 32'd50,         1'b0, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'd100,        1'b0, 10'd0,   SRC_NONE},
    '{KIND_TRIGGER, 32'd150,        1'b0, 10'd0,   SRC_NONE},
    '{KIND_FALL,    32'd1100,       1'b0, 10'd0,   SRC_NONE},
    '{KIND_READ,    32'd0,          1'b1, 10'd17,  SRC_LATEST},
    '{KIND_TRIGGER, 32'd0,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'hFFFF_FFF0,  1'b0, 10'd0,   SRC_NONE},
    '{KIND_FALL,    32'h0000_0010,  1'b0, 10'd0,   SRC_NONE},
    '{KIND_READ,    32'hFFFF_FFFF,  1'b1, 10'd0,   SRC_LATEST},
    '{KIND_TRIGGER, 32'd0,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'd0,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_FALL,    32'hFFFF_FFFF,  1'b0, 10'd0,   SRC_NONE},
    '{KIND_READ,    32'd0,          1'b1, 10'd450, SRC_LATEST},
    '{KIND_TRIGGER, 32'd0,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'd3,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_RISE,    32'd7,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_FALL,    32'd7,          1'b0, 10'd0,   SRC_NONE},
    '{KIND_READ,    32'd0,          1'b1, 10'd0,   SRC_LATEST}
  };

  echo_range_median_filter_top #(
    .WINDOW(WIN)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_time_us     (in_time_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_distance_cm(out_distance_cm),
    .out_source     (out_source),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("echo_range_median_filter_top verification failed");
    $finish;
  end

  function automatic logic [DIST_W-1:0] to_centimeters(input logic [SAMPLE_W-1:0] t);
    logic [63:0] p;
    p = (64'(t) * 64'd1716) / 64'd100000;
    return p[DIST_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] window_middle();
    logic [SAMPLE_W-1:0] srt [WIN];
    logic [SAMPLE_W-1:0] v;
    int                  j;
    srt = ring_q;
    for (int i = 1; i < WIN; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    return srt[WIN/2];
  endfunction

  // advances the predicted state; returns 0 only for edges ignored while disarmed
  function automatic bit apply_echo_event(input erm_kind_t k, input logic [TIME_W-1:0] t,
                                          output bit has_reading, output reading_t rd);
    logic [TIME_W-1:0] el;
    has_reading = 1'b0;
    rd = '{cm: '0, src: SRC_NONE};
    case (k)
      KIND_TRIGGER: begin
        armed_q = 1'b1;
        return 1'b1;
      end
      KIND_RISE: begin
        if (armed_q) start_q = t;
        return armed_q;
      end
      KIND_FALL: begin
        if (!armed_q) return 1'b0;
        armed_q = 1'b0;
        el = t - start_q;
        if (el > TIME_W'(limit_q)) el = TIME_W'(limit_q);
        ring_q[wr_idx_q] = el[SAMPLE_W-1:0];
        wr_idx_q = (wr_idx_q + 1) % WIN;
        if (wr_idx_q == 0) full_q = 1'b1;
        return 1'b1;
      end
      default: begin
        has_reading = 1'b1;
        if (full_q) begin
          rd = '{cm: to_centimeters(window_middle()), src: SRC_MEDIAN};
        end else if (wr_idx_q != 0) begin
          rd = '{cm: to_centimeters(ring_q[wr_idx_q-1]), src: SRC_LATEST};
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_event(input erm_kind_t k, input logic [TIME_W-1:0] t,
                            input bit fixed = 1'b0, input logic [DIST_W-1:0] fcm = '0,
                            input erm_src_t fsrc = SRC_NONE);
    bit       has_reading;
    reading_t rd;
    int       r;
    int       gap;
    @(negedge clk);
    in_valid   = 1'b1;
    in_kind    = k;
    in_time_us = t;
    do @(posedge clk); while (in_stall);
    if (apply_echo_event(k, t, has_reading, rd)) effective_sent++;
    if (has_reading) begin
      if (fixed) rd = '{cm: fcm, src: fsrc};
      pending_readings.push_back(rd);
    end
    r = $urandom_range(0, 99);
    gap = (calm_sender || r < 70) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic set_echo_limit(input logic [SAMPLE_W-1:0] v);
    wait_drained();
    // a falling edge or read may still be in flight inside the block
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    limit_q = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_echo_traffic(input int n);
    int                goal;
    int                r;
    bit                paused;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] el;
    goal = effective_sent + n;
    paused = 1'b0;
    while (effective_sent < goal) begin
      if (!paused && effective_sent >= goal - n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r  = $urandom_range(0, 99);
      t0 = $urandom();
      if (r < 78) begin
        send_event(KIND_TRIGGER, t0 - $urandom_range(0, 500));
        if ($urandom_range(0, 9) == 0) send_event(KIND_RISE, t0 - $urandom_range(1, 900));
        send_event(KIND_RISE, t0);
        if ($urandom_range(0, 9) == 0) send_event(KIND_TRIGGER, $urandom());
        r = $urandom_range(0, 99);
        if (r < 35)      el = $urandom_range(0, int'(limit_q) + 3);
        else if (r < 55) el = TIME_W'(limit_q) + $urandom_range(0, 4) - 2;
        else if (r < 70) el = $urandom_range(0, 100);
        else if (r < 85) el = $urandom();
        else             el = $urandom_range(0, 32767);
        send_event(KIND_FALL, t0 + el);
        if ($urandom_range(0, 1) == 0) send_event(KIND_READ, $urandom());
      end else begin
        // loose events: stray edges, lone triggers and reads
        send_event(erm_kind_t'($urandom_range(0, 3)), $urandom());
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unrequested result, distance", int'(out_distance_cm), -1);
      end else begin
        want = pending_readings.pop_front();
        if (out_distance_cm !== want.cm)
          report_mismatch("distance_cm", int'(out_distance_cm), int'(want.cm));
        if (out_source !== want.src)
          report_mismatch("source", int'(out_source), int'(want.src));
      end
    end
  end

  // result-side stalls: mostly short bursts, some long, some long free stretches
  initial begin
    int r;
    int len;
    bit st;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55)      begin st = 1'b0; len = $urandom_range(1, 12);   end
      else if (r < 65) begin st = 1'b0; len = $urandom_range(40, 200); end
      else if (r < 93) begin st = 1'b1; len = $urandom_range(1, 3);    end
      else             begin st = 1'b1; len = $urandom_range(10, 40);  end
      @(negedge clk);
      out_stall = st;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) ring_q[i] = '0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_TRIGGER;
    in_time_us = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      send_event(plan[i].kind, plan[i].stamp, plan[i].fixed, plan[i].cm, plan[i].src);

    run_echo_traffic(170);
    set_echo_limit(15'd32767);
    calm_sender = 1'b1;
    run_echo_traffic(180);
    calm_sender = 1'b0;
    set_echo_limit(15'd1);
    run_echo_traffic(150);
    set_echo_limit(15'd0);
    run_echo_traffic(100);
    set_echo_limit(SAMPLE_W'($urandom_range(2, 40)));
    run_echo_traffic(100);
    set_echo_limit(SAMPLE_W'($urandom_range(1, 32767)));
    run_echo_traffic(195);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("echo_range_median_filter_top verification clean");
    end else begin
      $display("echo_range_median_filter_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/erm_pkg.sv
hw/rtl/erm_sort_cell.sv
hw/rtl/erm_scale.sv
hw/rtl/echo_range_median_filter_top.sv
tb/sv/echo_range_median_filter_top_tb.sv
